/* design/wmam_pkg.sv */
// ----------------------------------------------------------------------------
// wmam_pkg
// Shared types, constants and helpers of the weekly minute alarm matcher.
// ----------------------------------------------------------------------------
package wmam_pkg;

   localparam int unsigned DefaultEntries = 16;
   localparam int unsigned IndexW         = 4;
   localparam int unsigned IndexSpan      = 1 << IndexW;
   localparam int unsigned MinuteW        = 11;
   localparam int unsigned MaskW          = 8;
   localparam int unsigned SecondsW       = 32;
   localparam int unsigned DayW           = 3;
   localparam int unsigned MaxEvents      = 16;
   localparam int unsigned FoundW         = $clog2(MaxEvents + 1);
   localparam int unsigned SlotNumW       = 7;

   localparam logic FuncWrite = 1'b0;
   localparam logic FuncTick  = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [IndexW-1:0]     entry_index;
      logic                  entry_is_timer;
      logic [MinuteW-1:0]    entry_minute;
      logic [MaskW-1:0]      day_mask;
      logic                  fire_polarity;
      logic [SecondsW-1:0]   time_seconds;
      logic [DayW-1:0]       week_day;
   } req_payload_type;

   typedef struct packed {
      logic [IndexW-1:0]     event_index;
      logic                  event_level;
      logic                  last_event;
   } rsp_payload_type;

   typedef struct packed {
      logic                  is_timer;
      logic [MinuteW-1:0]    minute;
      logic [MaskW-1:0]      day_mask;
      logic                  polarity;
   } entry_type;

   // bit 7 enables every weekday; weekday seven is never allowed
   function automatic logic day_ok(input logic [MaskW-1:0] mask,
                                   input logic [DayW-1:0] day);
      logic [MaskW-1:0] m;
      m = mask[MaskW-1] ? 8'h7F : {1'b0, mask[MaskW-2:0]};
      return m[day];
   endfunction

endpackage

/* design/wmam_chan_if.sv */
// ----------------------------------------------------------------------------
// wmam_chan_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface wmam_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/wmam_conv.sv */
// ----------------------------------------------------------------------------
// wmam_conv
// Epoch seconds to minute of day by reciprocal multiplication: a 32x32
// product gives the minutes since the epoch, a second one the count of
// whole days, and a final subtract leaves the minute.
// Registers seconds, epoch minutes, whole days and minute of day in turn; done rises with minute.
// ----------------------------------------------------------------------------
module wmam_conv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wmam_pkg::SecondsW-1:0] seconds,
   output logic                          done,
   output logic [wmam_pkg::MinuteW-1:0]  minute
);
   import wmam_pkg::*;

   // minutes since the epoch stay below 2^27
   localparam int unsigned QuotW  = 27;
   localparam int unsigned LowW   = 5;
   localparam int unsigned HighW  = QuotW - LowW;
   localparam int unsigned Prod1W = 2 * SecondsW;
   localparam int unsigned Shift1 = 37;
   // ceil(2^37 / 60), exact for every 32-bit input
   localparam logic [SecondsW-1:0] Recip60 = 32'h8888_8889;
   localparam int unsigned RecipW = HighW + 1;
   localparam int unsigned Prod2W = HighW + RecipW;
   localparam int unsigned Shift2 = 28;
   // ceil(2^28 / 45), exact for every 22-bit input
   localparam logic [RecipW-1:0] Recip45 = 23'd5965233;
   localparam int unsigned BlkW   = 16;
   localparam int unsigned RemW   = MinuteW - LowW;
   // 1440 minutes = 45 blocks of 32
   localparam logic [HighW-1:0] DayBlocks = 22'd45;

   logic [SecondsW-1:0] sec_ff, sec_in;
   logic [QuotW-1:0]    quot_ff, quot_in;
   logic [BlkW-1:0]     blk_ff, blk_in;
   logic [MinuteW-1:0]  min_ff, min_in;
   logic                v1_ff, v2_ff, v3_ff;
   logic                done_ff;

   always_comb begin
      logic [Prod1W-1:0] prod1;
      logic [Prod2W-1:0] prod2;
      logic [HighW-1:0]  rem;
      prod1   = Prod1W'(sec_ff) * Prod1W'(Recip60);
      prod2   = Prod2W'(quot_ff[QuotW-1:LowW]) * Prod2W'(Recip45);
      rem     = quot_ff[QuotW-1:LowW] - HighW'(blk_ff) * DayBlocks;
      sec_in  = start ? seconds : sec_ff;
      quot_in = v1_ff ? prod1[Shift1 +: QuotW] : quot_ff;
      blk_in  = v2_ff ? prod2[Shift2 +: BlkW] : blk_ff;
      min_in  = v3_ff ? {rem[RemW-1:0], quot_ff[LowW-1:0]} : min_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         done_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sec_ff  <= sec_in;
      quot_ff <= quot_in;
      blk_ff  <= blk_in;
      min_ff  <= min_in;
   end

   assign done   = done_ff;
   assign minute = min_ff;

endmodule

/* design/wmam_cell.sv */
// ----------------------------------------------------------------------------
// wmam_cell
// One alarm slot of the rotating ring. Loads on a table write, takes its
// neighbor's slot on each scan shift.
// ----------------------------------------------------------------------------
module wmam_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  wmam_pkg::entry_type load_data,
   input  logic                shift,
   input  wmam_pkg::entry_type nbr,
   output wmam_pkg::entry_type slot
);
   import wmam_pkg::*;

   logic               is_timer_ff;
   logic [MinuteW-1:0] minute_ff;
   logic [MaskW-1:0]   mask_ff;
   logic               pol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_timer_ff <= 1'b0;
      end else if (load) begin
         is_timer_ff <= load_data.is_timer;
      end else if (shift) begin
         is_timer_ff <= nbr.is_timer;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         minute_ff <= load_data.minute;
         mask_ff   <= load_data.day_mask;
         pol_ff    <= load_data.polarity;
      end else if (shift) begin
         minute_ff <= nbr.minute;
         mask_ff   <= nbr.day_mask;
         pol_ff    <= nbr.polarity;
      end
   end

   assign slot = '{is_timer: is_timer_ff, minute: minute_ff,
                   day_mask: mask_ff, polarity: pol_ff};

endmodule

/* design/weekly_minute_alarm_matcher.sv */
// ----------------------------------------------------------------------------
// weekly_minute_alarm_matcher
// Alarm table held in a ring of slot cells; a tick converts epoch seconds to
// a minute of day and, on a new minute, rotates the ring once past the head
// cell, reporting each timer slot that fires.
//
//   channel  dir  payload
//   req      in   func, entry_index, entry fields, time_seconds, week_day
//   rsp      out  event_index, event_level, last_event
//
// Table write: loads its cell directly. Tick: minute conversion, then, on a
// new minute, ring rotation over ENTRIES slots and a flush of the last event.
// The ring rotation sets the scan length; rsp back pressure stalls it.
// Reset clears every slot's timer flag and the previous minute.
// A pending response may wait in its output register while req is taken.
// ----------------------------------------------------------------------------
module weekly_minute_alarm_matcher #(
   parameter int unsigned ENTRIES = wmam_pkg::DefaultEntries
) (
   input  logic        clock,
   input  logic        reset,
   wmam_chan_if.sink   req,
   wmam_chan_if.source rsp
);
   import wmam_pkg::*;

   localparam int unsigned StepW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic [IndexW-1:0] idx;
      logic              level;
   } pend_type;

   state_type          state_ff, state_in;
   logic [MinuteW-1:0] prev_ff, prev_in;
   logic [DayW-1:0]    day_ff, day_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic [FoundW-1:0]  found_ff, found_in;
   logic               pend_valid_ff, pend_valid_in;
   pend_type           pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   req_payload_type    rq;
   logic               req_take;
   logic               conv_done;
   logic [MinuteW-1:0] conv_minute;
   logic               shift;
   entry_type          wr_entry;
   entry_type          cell_q [ENTRIES];

   assign rq       = req.payload;
   assign req.ready = (state_ff == ST_IDLE);
   assign req_take = req.valid && (state_ff == ST_IDLE);

   wmam_conv u_conv (
      .clock   (clock),
      .reset   (reset),
      .start   (req_take && rq.func == FuncTick),
      .seconds (rq.time_seconds),
      .done    (conv_done),
      .minute  (conv_minute)
   );

   assign wr_entry = '{is_timer: rq.entry_is_timer, minute: rq.entry_minute,
                       day_mask: rq.day_mask, polarity: rq.fire_polarity};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      wmam_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (req_take && rq.func == FuncWrite && (i < IndexSpan) &&
                     rq.entry_index == IndexW'(i)),
         .load_data (wr_entry),
         .shift     (shift),
         .nbr       (cell_q[(i + 1) % ENTRIES]),
         .slot      (cell_q[i])
      );
   end

   always_comb begin
      logic                hit;
      logic                out_free;
      logic                advance;
      logic [SlotNumW-1:0] slot_num;
      state_in      = state_ff;
      prev_in       = prev_ff;
      day_in        = day_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_data_in   = rsp_data_ff;
      shift         = 1'b0;
      out_free      = !rsp_valid_ff || rsp.ready;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      slot_num      = SlotNumW'(step_ff);
      hit = cell_q[0].is_timer && cell_q[0].minute == prev_ff &&
            day_ok(cell_q[0].day_mask, day_ff) && found_ff != FoundW'(MaxEvents);
      advance = !hit || !pend_valid_ff || out_free;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && rq.func == FuncTick) begin
               day_in   = rq.week_day;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               if (conv_minute == prev_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  prev_in       = conv_minute;
                  step_in       = '0;
                  found_in      = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (advance) begin
               shift = 1'b1;
               if (hit) begin
                  // a new event displaces the held one, which is not the last
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{event_index: pend_ff.idx,
                                      event_level: pend_ff.level,
                                      last_event: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = '{idx: slot_num[IndexW-1:0],
                                    level: cell_q[0].polarity};
                  found_in      = found_ff + 1'b1;
               end
               step_in = step_ff + 1'b1;
               if (step_ff == StepW'(ENTRIES - 1)) begin
                  step_in  = '0;
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '{event_index: pend_ff.idx,
                                 event_level: pend_ff.level,
                                 last_event: 1'b1};
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_ff       <= '0;
         step_ff       <= '0;
         found_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff      <= day_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

endmodule

/* dv/wmam_alarm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmam_alarm_checker
// Watches both channels of the alarm matcher. It keeps its own copy of the
// alarm table and the last minute, and works out the events of every
// accepted tick. Each response is compared field by field with the oldest
// event still due.
// ----------------------------------------------------------------------------
module wmam_alarm_checker #(
   parameter int unsigned SLOTS = wmam_pkg::DefaultEntries
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  wmam_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  wmam_pkg::rsp_payload_type rsp_payload,
   output int                        mismatches,
   output int                        outstanding,
   output int                        events_checked,
   output int                        minute_scans
);
   import wmam_pkg::*;

   entry_type          alarm_slot [SLOTS];
   logic [MinuteW-1:0] last_minute = '0;
   rsp_payload_type    due_events [$];
   int                 fail_total = 0;
   int                 event_total = 0;
   int                 scan_total = 0;

   function automatic logic [MinuteW-1:0] seconds_to_minute(
      input logic [SecondsW-1:0] secs);
      int unsigned hour_of_day;
      int unsigned minute_of_hour;
      hour_of_day    = (secs / 3600) % 24;
      minute_of_hour = (secs / 60) % 60;
      return MinuteW'(hour_of_day * 60 + minute_of_hour);
   endfunction

   // mask bit 7 opens all seven days; weekday 7 has no bit at all
   function automatic logic weekday_enabled(input logic [MaskW-1:0] mask,
                                            input logic [DayW-1:0] day);
      logic [6:0] days;
      days = mask[7] ? 7'h7F : mask[6:0];
      if (day == 3'd7) return 1'b0;
      return days[day];
   endfunction

   task automatic predict_request(input req_payload_type item);
      logic [MinuteW-1:0] now;
      rsp_payload_type    ev;
      int                 fired;
      fired = 0;
      if (item.func == FuncWrite) begin
         if (item.entry_index < SLOTS) begin
            alarm_slot[item.entry_index].is_timer = item.entry_is_timer;
            alarm_slot[item.entry_index].minute   = item.entry_minute;
            alarm_slot[item.entry_index].day_mask = item.day_mask;
            alarm_slot[item.entry_index].polarity = item.fire_polarity;
         end
      end else begin
         now = seconds_to_minute(item.time_seconds);
         if (now != last_minute) begin
            last_minute = now;
            scan_total++;
            for (int i = 0; i < SLOTS && fired < MaxEvents; i++) begin
               if (alarm_slot[i].is_timer && alarm_slot[i].minute == now &&
                   weekday_enabled(alarm_slot[i].day_mask, item.week_day)) begin
                  ev.event_index = IndexW'(i);
                  ev.event_level = alarm_slot[i].polarity;
                  ev.last_event  = 1'b0;
                  due_events.push_back(ev);
                  fired++;
               end
            end
            if (fired > 0) due_events[$].last_event = 1'b1;
         end
      end
   endtask

   task automatic check_event(input rsp_payload_type got);
      rsp_payload_type want;
      event_total++;
      if (due_events.size() == 0) begin
         fail_total++;
         if (fail_total <= 10)
            $display("%0t: unexpected event idx=%0d lvl=%0b last=%0b", $realtime,
                     got.event_index, got.event_level, got.last_event);
      end else begin
         want = due_events.pop_front();
         if (got.event_index !== want.event_index ||
             got.event_level !== want.event_level ||
             got.last_event  !== want.last_event) begin
            fail_total++;
            if (fail_total <= 10)
               $display("%0t: event mismatch: expected idx=%0d lvl=%0b last=%0b,",
                        $realtime, want.event_index, want.event_level, want.last_event,
                        " got idx=%0d lvl=%0b last=%0b",
                        got.event_index, got.event_level, got.last_event);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) alarm_slot[i].is_timer = 1'b0;
         last_minute = '0;
         due_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_event(rsp_payload);
         if (req_valid && req_ready) predict_request(req_payload);
      end
      mismatches     <= fail_total;
      outstanding    <= due_events.size();
      events_checked <= event_total;
      minute_scans   <= scan_total;
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the alarm matcher testbench. Drives table writes and time ticks,
// first a directed set around the corner cases, then random traffic aimed
// at the stored minutes, with random gaps on both channels and one long
// response stall. The checker beside the block does all comparisons.
// ----------------------------------------------------------------------------
module tb;
   import wmam_pkg::*;

   localparam int RandomRequests = 345;
   localparam int StallCycles    = 400;
   localparam int DrainCycles    = 60;
   localparam int CycleLimit     = 400000;

   logic clock;
   logic reset;
   logic rsp_want;
   logic rsp_hold;

   int mismatches;
   int outstanding;
   int events_checked;
   int minute_scans;
   int write_count;
   int tick_count;
   int cycle_count = 0;
   int req_streak;
   int rsp_streak = 0;

   logic [MinuteW-1:0]  hot_minute [4];
   logic [SecondsW-1:0] last_seconds;

   wmam_chan_if #(.payload_type(req_payload_type)) req_if ();
   wmam_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   assign rsp_if.ready = rsp_want && !rsp_hold;

   weekly_minute_alarm_matcher dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   wmam_alarm_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_payload    (req_if.payload),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_payload    (rsp_if.payload),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .events_checked (events_checked),
      .minute_scans   (minute_scans)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // idle cycles before the next request; now and then a run with no gaps
   function automatic int draw_wait(inout int streak);
      if (streak > 0) begin
         streak--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) streak = $urandom_range(10, 30);
      return $urandom_range(0, 5);
   endfunction

   function automatic req_payload_type write_req(input int idx, input logic timer,
                                                 input int minute, input int mask,
                                                 input logic pol);
      req_payload_type p;
      p                = '0;
      p.func           = FuncWrite;
      p.entry_index    = IndexW'(idx);
      p.entry_is_timer = timer;
      p.entry_minute   = MinuteW'(minute);
      p.day_mask       = MaskW'(mask);
      p.fire_polarity  = pol;
      // tick fields ride along and must be ignored
      p.time_seconds   = $urandom;
      p.week_day       = DayW'($urandom_range(0, 7));
      return p;
   endfunction

   function automatic req_payload_type tick_req(input logic [SecondsW-1:0] secs,
                                                input int day);
      req_payload_type p;
      p                = '0;
      p.func           = FuncTick;
      p.entry_index    = IndexW'($urandom_range(0, 15));
      p.entry_is_timer = 1'($urandom_range(0, 1));
      p.entry_minute   = MinuteW'($urandom_range(0, 2047));
      p.day_mask       = MaskW'($urandom_range(0, 255));
      p.fire_polarity  = 1'($urandom_range(0, 1));
      p.time_seconds   = secs;
      p.week_day       = DayW'(day);
      return p;
   endfunction

   task automatic send_request(input req_payload_type p);
      int gap;
      gap = draw_wait(req_streak);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (!req_if.ready);
      if (p.func == FuncWrite) write_count++;
      else tick_count++;
      if (p.func == FuncTick) last_seconds = p.time_seconds;
   endtask

   task automatic send_random_request();
      longint unsigned secs;
      int              pick;
      int              minute;
      if ($urandom_range(0, 19) == 0)
         hot_minute[$urandom_range(0, 3)] = MinuteW'($urandom_range(0, 1439));
      if ($urandom_range(0, 9) < 4) begin
         minute = ($urandom_range(0, 9) < 7) ? int'(hot_minute[$urandom_range(0, 3)])
                                            : int'($urandom_range(0, 2047));
         send_request(write_req($urandom_range(0, 15), $urandom_range(0, 9) != 0, minute,
                                $urandom_range(0, 255), 1'($urandom_range(0, 1))));
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            secs = longint'($urandom_range(0, 49709)) * 86400 +
                   hot_minute[$urandom_range(0, 3)] * 60 + $urandom_range(0, 59);
         end else if (pick < 8) begin
            // another tick within the minute of the previous one
            secs = last_seconds - (last_seconds % 60) + $urandom_range(0, 59);
            if (secs > 64'hFFFF_FFFF) secs = last_seconds;
         end else begin
            secs = $urandom;
         end
         send_request(tick_req(SecondsW'(secs), $urandom_range(0, 7)));
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d events still due", cycle_count, outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response side
   initial begin
      int gap;
      rsp_want <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_wait(rsp_streak);
         if (gap > 0) begin
            rsp_want <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_want <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // one long response stall once traffic is flowing, so the table scan
   // backs up into the request channel
   initial begin
      int taken;
      taken = 0;
      rsp_hold <= 1'b0;
      while (taken < 60) begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) taken++;
      end
      rsp_hold <= 1'b1;
      repeat (StallCycles) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      write_count  = 0;
      tick_count   = 0;
      req_streak   = 0;
      last_seconds = '0;
      for (int i = 0; i < 4; i++) hot_minute[i] = MinuteW'($urandom_range(0, 1439));
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // minute zero matches the reset value of the last minute: silent
      send_request(tick_req(32'd0, 0));
      // fill the table with alarms at 23:59
      for (int i = 0; i < 16; i++)
         send_request(write_req(i, 1'b1, 1439, (i == 15) ? 8'hFF : (i[0] ? 8'h08 : 8'h80),
                                1'(i[0] ^ i[1])));
      send_request(tick_req(32'd86399, 3));           // all sixteen fire
      send_request(tick_req(32'd86340 + 32'd604800, 3)); // same minute, no scan
      send_request(tick_req(32'hFFFF_FFFF, 6));       // top of the seconds range
      send_request(tick_req(32'd172799, 7));          // weekday 7 never fires
      send_request(write_req(0, 1'b1, 2047, 8'hFF, 1'b1)); // minute out of range
      send_request(tick_req(32'd259200, 0));          // midnight, nothing matches
      send_request(write_req(1, 1'b0, 0, 8'hFF, 1'b1));    // slot disabled
      send_request(tick_req(32'd345599, 5));

      for (int n = 0; n < RandomRequests; n++) send_random_request();
      req_if.valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Run covered %0d table writes and %0d ticks; %0d minute scans",
               write_count, tick_count, minute_scans);
      $display("and %0d alarm events compared, %0d mismatches", events_checked, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
